// ===== src/gpwc_pkg.sv =====
// Shared constants and control types for the grid palindrome window counter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package gpwc_pkg;

	// Default largest grid side that the symbol memory holds.
	localparam int GRID_MAX_DEF = 128;

	localparam int SYM_W     = 8;   // one grid symbol
	localparam int CFG_W     = 8;   // configuration data
	localparam int CFG_IDX_W = 8;   // configuration register index
	localparam int CNT_W     = 16;  // palindrome count
	localparam int LIN_W     = 16;  // linear cell position, covers 255 * 255 cells

	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] GRID_SIZE_RST  = CFG_W'(100);
	localparam logic [CFG_W-1:0] WINDOW_LEN_RST = CFG_W'(2);

	// Command from the top level to the window walker.
	typedef struct packed {
		logic start;      // last symbol of a grid was just accepted
		logic sink_free;  // output register can take a count this cycle
	} walk_cmd_t;

	// Status from the window walker to the top level.
	typedef struct packed {
		logic             busy;   // walk in progress, no symbols taken
		logic             done;   // count handed over this cycle
		logic [CNT_W-1:0] count;
	} walk_stat_t;

endpackage

// ===== src/gpwc_if.sv =====
// Handshake channel interfaces of the grid palindrome window counter:
// symbol input, count output and configuration writes. Depends on gpwc_pkg.
`timescale 1ns / 1ps

interface gpwc_sym_if;
	import gpwc_pkg::*;
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink (input valid, input symbol, input last, output ready);
endinterface

interface gpwc_cnt_if;
	import gpwc_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] palindrome_count;

	modport source (output valid, output palindrome_count, input ready);
	modport sink (input valid, input palindrome_count, output ready);
endinterface

interface gpwc_cfg_if;
	import gpwc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/gpwc_walker.sv =====
// Window walker: steps through every row and column window of the stored grid
// with one shared multiplier and one memory read port. Depends on gpwc_pkg.
`timescale 1ns / 1ps

module gpwc_walker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gpwc_pkg::walk_cmd_t     cmd,
	input  logic [7:0]              grid_n,
	input  logic [7:0]              win_k,
	input  logic [gpwc_pkg::SYM_W-1:0] rd_data,
	output logic [gpwc_pkg::LIN_W-1:0] rd_addr,
	output gpwc_pkg::walk_stat_t    stat
);
	import gpwc_pkg::*;

	typedef enum logic [7:0] {
		W_IDLE = 8'b0000_0001,
		W_SPAN = 8'b0000_0010,
		W_BASE = 8'b0000_0100,
		W_YA   = 8'b0000_1000,
		W_RDX  = 8'b0001_0000,
		W_RDY  = 8'b0010_0000,
		W_CMP  = 8'b0100_0000,
		W_DONE = 8'b1000_0000
	} wstate_t;

	wstate_t            state_q;
	logic [7:0]         n_q, k_q, last_start_q, line_q, start_q;
	logic [6:0]         half_q, a_q;
	logic               dir_q;
	logic [LIN_W-1:0]   kn_q, xa_q, ya_q;
	logic [SYM_W-1:0]   x_q;
	logic [CNT_W-1:0]   tally_q;
	logic               next_win;

	logic [7:0]       mul_a;
	logic [LIN_W-1:0] prod, step;
	logic [CNT_W-1:0] tally_inc;

	// The one multiplier serves the column span (k-1)*n and every window base.
	assign mul_a = (state_q == W_SPAN) ? (k_q - 8'd1) : (dir_q ? start_q : line_q);
	assign prod  = {8'b0, mul_a} * {8'b0, n_q};
	assign step  = dir_q ? {8'b0, n_q} : LIN_W'(1);
	assign tally_inc = (tally_q == {CNT_W{1'b1}}) ? tally_q : tally_q + CNT_W'(1);

	assign rd_addr    = (state_q == W_RDY) ? ya_q : xa_q;
	assign stat.busy  = (state_q != W_IDLE);
	assign stat.done  = (state_q == W_DONE) && cmd.sink_free;
	assign stat.count = tally_q;

	// Marks the end of the current window, whether it matched or not.
	always_comb begin
		next_win = 1'b0;
		case (state_q)
			W_YA:    next_win = (half_q == 7'd0);
			W_CMP:   next_win = (x_q != rd_data) || (a_q + 7'd1 == half_q);
			default: next_win = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			tally_q <= '0;
		end else begin
			case (state_q)
				W_IDLE: begin
					if (cmd.start) begin
						tally_q <= '0;
						if (grid_n == 8'd0 || win_k == 8'd0 || win_k > grid_n) begin
							state_q <= W_DONE;
						end else begin
							state_q <= W_SPAN;
						end
					end
				end
				W_SPAN: begin
					state_q <= W_BASE;
				end
				W_BASE: begin
					state_q <= W_YA;
				end
				W_YA: begin
					if (next_win) begin
						tally_q <= tally_inc;
					end else begin
						state_q <= W_RDX;
					end
				end
				W_RDX: begin
					state_q <= W_RDY;
				end
				W_RDY: begin
					state_q <= W_CMP;
				end
				W_CMP: begin
					if (next_win) begin
						if (x_q == rd_data) begin
							tally_q <= tally_inc;
						end
					end else begin
						state_q <= W_RDX;
					end
				end
				W_DONE: begin
					if (cmd.sink_free) begin
						state_q <= W_IDLE;
					end
				end
				default: state_q <= W_IDLE;
			endcase
			// Advance to the next window: row then column, then next start, then next line.
			if (next_win) begin
				state_q <= W_BASE;
				if (dir_q && start_q == last_start_q && line_q == n_q - 8'd1) begin
					state_q <= W_DONE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			W_IDLE: begin
				n_q          <= grid_n;
				k_q          <= win_k;
				half_q       <= win_k[7:1];
				last_start_q <= grid_n - win_k;
				line_q       <= '0;
				start_q      <= '0;
				dir_q        <= 1'b0;
			end
			W_SPAN: begin
				kn_q <= prod;
			end
			W_BASE: begin
				xa_q <= prod + {8'b0, (dir_q ? line_q : start_q)};
			end
			W_YA: begin
				ya_q <= xa_q + (dir_q ? kn_q : {8'b0, k_q - 8'd1});
				a_q  <= '0;
			end
			W_RDY: begin
				x_q <= rd_data;
			end
			W_CMP: begin
				a_q  <= a_q + 7'd1;
				xa_q <= xa_q + step;
				ya_q <= ya_q - step;
			end
			default: begin
			end
		endcase
		if (next_win) begin
			dir_q <= ~dir_q;
			if (dir_q) begin
				if (start_q == last_start_q) begin
					start_q <= '0;
					line_q  <= line_q + 8'd1;
				end else begin
					start_q <= start_q + 8'd1;
				end
			end
		end
	end

endmodule

// ===== src/grid_palindrome_window_counter_core.sv =====
// Top level of the grid palindrome window counter: symbol memory, load
// position, configuration registers and output register. Depends on gpwc_pkg,
// gpwc_if and gpwc_walker.
`timescale 1ns / 1ps

// The block loads a square grid of 8-bit symbols in row-major order, one item
// per cycle, into an internal memory of GRID_MAX * GRID_MAX entries. The item
// flagged last starts a walk over every window of window_len symbols in every
// row and every column of the grid_size by grid_size grid (grid_size capped
// at GRID_MAX); each window that reads the same both ways adds one to the
// count, which saturates at 65535 and leaves as one item on the counts
// channel. During the walk no symbol is taken. Each window first sets up its
// base address, then its mirrored address, and then compares symbol pairs
// with two reads each, because the single read port of the symbol memory
// delivers one symbol per cycle; a window stops at its first mismatch. An
// empty walk (zero size, zero length, or window longer than the grid)
// skips the windows and offers zero. Symbols are taken again from the cycle
// the count is offered; if an earlier count still waits in the output
// register, the walker holds its result and the input stays stalled until
// that count is taken. Symbols beyond the last grid cell are dropped, and
// cells not written for the current grid keep their earlier contents; cells
// never written since reset have no defined value. The configuration channel
// is always ready and should only be written while the block is idle.
module grid_palindrome_window_counter_core #(
	parameter int GRID_MAX = gpwc_pkg::GRID_MAX_DEF
) (
	input logic      clk,
	input logic      arst_n,
	gpwc_sym_if.sink   symbols,
	gpwc_cnt_if.source counts,
	gpwc_cfg_if.sink   cfg
);
	import gpwc_pkg::*;

	localparam int CELLS = GRID_MAX * GRID_MAX;
	localparam int AW    = $clog2(CELLS);

	// Configuration registers.
	logic [CFG_W-1:0] grid_size_q, window_len_q;

	// The effective grid side never exceeds GRID_MAX, nor 8 bits.
	logic [7:0]       eff_n;
	logic [LIN_W-1:0] cells;
	logic [LIN_W-1:0] load_pos_q;
	logic             sym_acc, wr_en;

	// Symbol memory, with its registered read port serving the walker.
	logic [SYM_W-1:0] grid_mem_q [CELLS];
	logic [SYM_W-1:0] rd_data_q;
	logic [LIN_W-1:0] rd_addr;
	logic [31:0]      wr_ext, rd_ext;

	walk_cmd_t  cmd;
	walk_stat_t stat;

	logic             out_valid_q;
	logic [CNT_W-1:0] out_count_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q  <= GRID_SIZE_RST;
			window_len_q <= WINDOW_LEN_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_GRID_SIZE:  grid_size_q  <= cfg.data;
				REG_WINDOW_LEN: window_len_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign eff_n = ({24'b0, grid_size_q} > GRID_MAX) ? 8'(GRID_MAX) : grid_size_q;
	assign cells = {8'b0, eff_n} * {8'b0, eff_n};

	// Symbols are taken whenever the walker is idle.
	assign symbols.ready = !stat.busy;
	assign sym_acc       = symbols.valid && !stat.busy;
	assign wr_en         = sym_acc && (load_pos_q < cells);

	// The position stays at the grid end on excess symbols and rewinds after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
		end else if (sym_acc) begin
			if (symbols.last) begin
				load_pos_q <= '0;
			end else if (wr_en) begin
				load_pos_q <= load_pos_q + LIN_W'(1);
			end
		end
	end

	assign wr_ext = {16'b0, load_pos_q};
	assign rd_ext = {16'b0, rd_addr};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			grid_mem_q[wr_ext[AW-1:0]] <= symbols.symbol;
		end
		rd_data_q <= grid_mem_q[rd_ext[AW-1:0]];
	end

	// The walk starts on the same edge that stores the last symbol.
	assign cmd.start     = sym_acc && symbols.last;
	assign cmd.sink_free = !out_valid_q || counts.ready;

	gpwc_walker u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.grid_n  (eff_n),
		.win_k   (window_len_q),
		.rd_data (rd_data_q),
		.rd_addr (rd_addr),
		.stat    (stat)
	);

	// Output register: the count waits here until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done) begin
			out_valid_q <= 1'b1;
		end else if (counts.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			out_count_q <= stat.count;
		end
	end

	assign counts.valid            = out_valid_q;
	assign counts.palindrome_count = out_count_q;

endmodule
